@@ rtl/core/sparse_row_variance_core_assert.svh @@
// ----------------------------------------------------------------------------
// Sparse row variance assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPARSE_ROW_VARIANCE_CORE_ASSERT_SVH
`define SPARSE_ROW_VARIANCE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SRV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRV_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define SRV_ASSERT(label, prop, msg)
`define SRV_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

@@ rtl/core/srv_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse row variance package
// Widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package srv_pkg;

    localparam int MAX_CELLS_DEF = 1048576;

    localparam int COUNT_W = 21;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 7;

    localparam logic [CNT_W-1:0] DIV_Q_STEPS = 7'd49;
    localparam logic [CNT_W-1:0] DIV_F_STEPS = 7'd64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [63:0]        U64_MAX   = {64{1'b1}};
    localparam logic [62:0]        OUT_MAX   = {63{1'b1}};

    // configuration register indexes
    localparam logic [1:0] REG_NUM_CELLS   = 2'd0;
    localparam logic [1:0] REG_CLIP_LIMIT  = 2'd1;
    localparam logic [1:0] REG_STANDARDIZE = 2'd2;

    localparam logic [COUNT_W-1:0] NUM_CELLS_RST  = 21'd2;
    localparam logic [DATA_W-1:0]  CLIP_LIMIT_RST = 32'd655360;

    typedef enum logic [3:0] {
        S_IDLE,
        S_E_DIV,
        S_E_CLIP,
        S_E_SQ,
        S_E_ACC,
        S_R_START,
        S_R_DIV,
        S_R_SQ,
        S_R_MLO,
        S_R_MHI,
        S_R_TOT,
        S_F_DIV,
        S_R_OUT
    } state_t;

endpackage

@@ rtl/core/sparse_row_variance_core.sv @@
// Entry: plain squares and accumulates; standardized first runs the 49-step shared divider.
// Row end after its last entry runs the 64-step final division, preceded in standardized
// mode by the 49-step mean/sd division on the same divider.
// Flow: ready only in idle; not ready while a request is in work.
// Reset: asynchronous active low, clears accumulators, sequencer and config to defaults.
// ----------------------------------------------------------------------------
// Sparse row variance core
// Accumulates squared deviations of sparse row entries and divides at row end.
// ----------------------------------------------------------------------------
`include "sparse_row_variance_core_assert.svh"

module sparse_row_variance_core #(
    parameter int MAX_CELLS = srv_pkg::MAX_CELLS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [srv_pkg::DATA_W-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [95:0]                 s_tdata,   // value, row_mean, row_sd
    input  logic                        s_tuser,   // has_value
    input  logic                        s_tlast,   // last_in_row
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,   // variance, zero pad
    output logic [1:0]                  m_tuser    // overflow, row_skipped
);
    import srv_pkg::*;

    localparam int CELLS_W = $clog2(MAX_CELLS + 1);
    localparam int CMP_W   = (CELLS_W > COUNT_W) ? CELLS_W : COUNT_W;
    localparam logic [CMP_W-1:0] CELLS_HI = CMP_W'(MAX_CELLS);
    localparam logic [CMP_W-1:0] CELLS_LO = CMP_W'(2);

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]      num_cells_reg;
    logic signed [DATA_W-1:0] clip_reg;
    logic                    std_cfg_reg;

    logic [63:0]        sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               sat_reg;
    logic [CNT_W-1:0]   div_cnt_reg;
    logic               out_valid_reg;

    logic [63:0]         quo_reg;
    logic [31:0]         rem_reg;
    logic [31:0]         divisor_reg;
    logic [63:0]         sq_reg;
    logic [95:0]         prod_reg;
    logic                d_neg_reg;
    logic [31:0]         mean_mag_reg;
    logic [31:0]         sd_reg;
    logic                std_reg;
    logic                last_reg;
    logic                skip_reg;
    logic [CELLS_W-1:0]  zeros_reg;
    logic [62:0]         out_var_reg;
    logic                out_ovf_reg;
    logic                out_skip_reg;

    // input decode
    logic signed [31:0] in_value, in_mean;
    logic [31:0]        in_sd;
    logic signed [32:0] in_d;
    logic [32:0]        in_d_mag;
    logic [31:0]        in_mean_mag;

    assign in_value    = s_tdata[31:0];
    assign in_mean     = s_tdata[63:32];
    assign in_sd       = s_tdata[95:64];
    assign in_d        = {in_value[31], in_value} - {in_mean[31], in_mean};
    assign in_d_mag    = in_d[32] ? 33'(-in_d) : 33'(in_d);
    assign in_mean_mag = in_mean[31] ? 32'(-in_mean) : 32'(in_mean);

    // cell count clamp and zero count
    logic [CMP_W-1:0]   num_ext, cells_c, count_ext;
    logic [CELLS_W-1:0] cells_w, zeros_c;

    assign num_ext   = CMP_W'(num_cells_reg);
    assign count_ext = CMP_W'(count_reg);
    assign cells_c   = (num_ext < CELLS_LO) ? CELLS_LO :
                       ((num_ext > CELLS_HI) ? CELLS_HI : num_ext);
    assign cells_w   = cells_c[CELLS_W-1:0];
    assign zeros_c   = (count_ext < cells_c) ? CELLS_W'(cells_c - count_ext) : '0;

    // shared restoring divider step
    logic [32:0] div_shift;
    logic        div_ge;
    logic [31:0] rem_step;

    assign div_shift = {rem_reg, quo_reg[63]};
    assign div_ge    = div_shift >= {1'b0, divisor_reg};
    assign rem_step  = div_ge ? 32'(div_shift - {1'b0, divisor_reg}) : div_shift[31:0];

    // clip of the signed quotient
    logic signed [49:0] z_s, clip_s, zc_s;
    logic [49:0]        zc_mag;

    assign z_s    = d_neg_reg ? -$signed({1'b0, quo_reg[48:0]}) : $signed({1'b0, quo_reg[48:0]});
    assign clip_s = {{18{clip_reg[31]}}, clip_reg};
    assign zc_s   = (z_s > clip_s) ? clip_s : z_s;
    assign zc_mag = zc_s[49] ? 50'(-zc_s) : 50'(zc_s);

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        sq_ovf;

    assign mul_p  = 64'(mul_a) * 64'(mul_b);
    assign sq_ovf = quo_reg[48:32] != '0;

    logic [64:0] acc_sum;
    logic [63:0] prod_sat;
    logic        prod_ovf;
    logic [64:0] tot_sum;

    assign acc_sum  = {1'b0, sum_reg} + {1'b0, sq_reg};
    assign prod_ovf = prod_reg[95:64] != '0;
    assign prod_sat = prod_ovf ? U64_MAX : prod_reg[63:0];
    assign tot_sum  = {1'b0, sum_reg} + {1'b0, prod_sat};

    logic accept, out_free, div_busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        if (std_cfg_reg)
                            state_next = (in_sd != '0) ? S_E_DIV : S_E_ACC;
                        else
                            state_next = S_E_SQ;
                    end
                    else if (s_tlast)
                        state_next = S_R_START;
                end
            end
            S_E_DIV:   state_next = (div_cnt_reg == CNT_W'(1)) ? S_E_CLIP : S_E_DIV;
            S_E_CLIP:  state_next = S_E_SQ;
            S_E_SQ:    state_next = S_E_ACC;
            S_E_ACC:   state_next = last_reg ? S_R_START : S_IDLE;
            S_R_START:
            begin
                if (std_reg && sd_reg == '0)
                    state_next = S_R_OUT;
                else if (std_reg)
                    state_next = S_R_DIV;
                else
                    state_next = S_R_SQ;
            end
            S_R_DIV:   state_next = (div_cnt_reg == CNT_W'(1)) ? S_R_SQ : S_R_DIV;
            S_R_SQ:    state_next = S_R_MLO;
            S_R_MLO:   state_next = S_R_MHI;
            S_R_MHI:   state_next = S_R_TOT;
            S_R_TOT:   state_next = S_F_DIV;
            S_F_DIV:   state_next = (div_cnt_reg == CNT_W'(1)) ? S_R_OUT : S_F_DIV;
            S_R_OUT:   state_next = out_free ? S_IDLE : S_R_OUT;
            default:   state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready = state_reg == S_IDLE;
        accept   = s_tvalid && (state_reg == S_IDLE);
        out_free = !out_valid_reg || m_tready;
        div_busy = (state_reg == S_E_DIV) || (state_reg == S_R_DIV) || (state_reg == S_F_DIV);
        unique case (state_reg)
            S_R_MLO:
            begin
                mul_a = sq_reg[31:0];
                mul_b = 32'(zeros_reg);
            end
            S_R_MHI:
            begin
                mul_a = sq_reg[63:32];
                mul_b = 32'(zeros_reg);
            end
            default:
            begin
                mul_a = quo_reg[31:0];
                mul_b = quo_reg[31:0];
            end
        endcase
    end

    // control state, accumulators and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_cells_reg <= NUM_CELLS_RST;
            clip_reg      <= CLIP_LIMIT_RST;
            std_cfg_reg   <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            sat_reg       <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_CELLS:   num_cells_reg <= cfg_data[COUNT_W-1:0];
                    REG_CLIP_LIMIT:  clip_reg      <= cfg_data;
                    REG_STANDARDIZE: std_cfg_reg   <= cfg_data[0];
                    default:         ;
                endcase
            end
            if (out_valid_reg && m_tready && !(state_reg == S_R_OUT && out_free))
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && s_tuser && std_cfg_reg && in_sd != '0)
                        div_cnt_reg <= DIV_Q_STEPS;
                end
                S_E_DIV, S_R_DIV, S_F_DIV:
                    div_cnt_reg <= div_cnt_reg - CNT_W'(1);
                S_E_SQ, S_R_SQ:
                begin
                    if (sq_ovf)
                        sat_reg <= 1'b1;
                end
                S_E_ACC:
                begin
                    sum_reg <= acc_sum[64] ? U64_MAX : acc_sum[63:0];
                    if (acc_sum[64])
                        sat_reg <= 1'b1;
                    if (count_reg != COUNT_MAX)
                        count_reg <= count_reg + COUNT_W'(1);
                end
                S_R_START:
                    div_cnt_reg <= DIV_Q_STEPS;
                S_R_TOT:
                begin
                    div_cnt_reg <= DIV_F_STEPS;
                    if (prod_ovf || tot_sum[64])
                        sat_reg <= 1'b1;
                end
                S_R_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sum_reg       <= '0;
                        count_reg     <= '0;
                        sat_reg       <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    d_neg_reg    <= in_d[32];
                    mean_mag_reg <= in_mean_mag;
                    sd_reg       <= in_sd;
                    std_reg      <= std_cfg_reg;
                    last_reg     <= s_tlast;
                    rem_reg      <= '0;
                    divisor_reg  <= in_sd;
                    sq_reg       <= '0;
                    if (std_cfg_reg)
                        quo_reg <= {in_d_mag, 31'b0};
                    else
                        quo_reg <= {31'b0, in_d_mag};
                end
            end
            S_E_DIV, S_R_DIV, S_F_DIV:
            begin
                rem_reg <= rem_step;
                quo_reg <= {quo_reg[62:0], div_ge};
            end
            S_E_CLIP:
                quo_reg <= {14'b0, zc_mag};
            S_E_SQ, S_R_SQ:
                sq_reg <= sq_ovf ? U64_MAX : mul_p;
            S_R_START:
            begin
                skip_reg    <= std_reg && sd_reg == '0;
                zeros_reg   <= zeros_c;
                rem_reg     <= '0;
                divisor_reg <= sd_reg;
                if (std_reg)
                    quo_reg <= {1'b0, mean_mag_reg, 31'b0};
                else
                    quo_reg <= {32'b0, mean_mag_reg};
            end
            S_R_MLO:
                prod_reg <= {32'b0, mul_p};
            S_R_MHI:
                prod_reg <= prod_reg + {mul_p, 32'b0};
            S_R_TOT:
            begin
                rem_reg     <= '0;
                divisor_reg <= 32'(cells_w - CELLS_W'(1));
                quo_reg     <= tot_sum[64] ? U64_MAX : tot_sum[63:0];
            end
            S_R_OUT:
            begin
                if (out_free)
                begin
                    out_skip_reg <= skip_reg;
                    if (skip_reg)
                    begin
                        out_var_reg <= '0;
                        out_ovf_reg <= 1'b0;
                    end
                    else
                    begin
                        out_var_reg <= quo_reg[63] ? OUT_MAX : quo_reg[62:0];
                        out_ovf_reg <= sat_reg || quo_reg[63];
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_var_reg};
    assign m_tuser  = {out_skip_reg, out_ovf_reg};

    `SRV_ASSERT(a_rem_below_divisor, div_busy |-> rem_reg < divisor_reg, "divider remainder out of range")
    `SRV_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready && (s_tuser || s_tlast), !s_tready, "ready right after a working request")
    `SRV_ASSERT(a_skip_is_zero, m_tvalid && m_tuser[1] |-> m_tdata == 64'd0 && !m_tuser[0], "skipped row with nonzero result")
    `SRV_ASSERT_NEXT(a_row_cleared, state_reg == S_R_OUT && out_free, sum_reg == 64'd0 && count_reg == '0 && !sat_reg, "row state not cleared")

endmodule
